/* hw/rtl/wsd_pkg.sv */
package wsd_pkg;

   localparam int LENGTH_BITS_DEFAULT = 64;

   // Second header byte length codes
   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

   typedef struct packed {
      logic       empty_frame;
      logic       frame_end;
      logic [6:0] message_type;
      logic [7:0] payload_byte;
   } rsp_type;

endpackage

/* hw/rtl/websocket_frame_deframer.sv */
// WebSocket frame deframer, receive side.
// req_ carries the received stream, one byte per transfer. rsp_ carries one
// transfer per payload byte, unmasked, with the frame's message type; tlast
// marks the last transfer of a frame. A frame with no payload gives a single
// transfer with tuser set, tlast set and a zero byte. Other header bytes give
// no transfer.
// A payload byte is unmasked as it is accepted and registered in the result
// registers. Bytes are accepted one per cycle while the skid register is
// empty; the header parser updates its state in the same cycle the byte is
// accepted. The result side has a main register and a one-entry skid register,
// so a byte can be accepted while a result waits. While both registers are
// full, req_tready is low until the main register drains.
// Reset clears the parser to expect the first header byte of a new frame and
// empties both result registers.
module websocket_frame_deframer #(
   parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] payload_byte, [14:8] message_type, [15] zero
   output logic        rsp_tlast,
   output logic        rsp_tuser    // [0] empty_frame
);

   logic             accept;
   logic             res_valid;
   wsd_pkg::rsp_type res;
   wsd_pkg::rsp_type out_data;

   assign accept = req_tvalid && req_tready;

   wsd_parser #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (accept),
      .rx_byte    (req_tdata),
      .res_valid  (res_valid),
      .res        (res)
   );

   wsd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = {1'b0, out_data.message_type, out_data.payload_byte};
   assign rsp_tlast = out_data.frame_end;
   assign rsp_tuser = out_data.empty_frame;

   // Upstream is only held off while a result is pending
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req_tready low with no result pending");

   // An empty frame result closes its frame and carries no byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata[7:0] == 8'd0))
      else $error("empty frame result malformed");

   // A result produced while the output is stalled fills the skid entry
   assert property (@(posedge clock) disable iff (reset)
      accept && res_valid && rsp_tvalid && !rsp_tready |=> !req_tready)
      else $error("stalled result not held in skid register");

   // An empty frame result is also marked as frame end
   assert property (@(posedge clock) disable iff (reset)
      res_valid && res.empty_frame |-> res.frame_end)
      else $error("empty frame result without frame end");

endmodule

/* hw/rtl/wsd_parser.sv */
module wsd_parser #(
   parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_valid,
   input  logic [7:0]       rx_byte,
   output logic             res_valid,
   output wsd_pkg::rsp_type res
);

   typedef enum logic [2:0] {
      PH_HDR0  = 3'd0,
      PH_HDR1  = 3'd1,
      PH_EXT16 = 3'd2,
      PH_EXT64 = 3'd3,
      PH_MASK  = 3'd4,
      PH_DATA  = 3'd5
   } phase_type;

   localparam logic [2:0] EXT16_LAST = 3'd1;
   localparam logic [2:0] EXT64_LAST = 3'd7;
   localparam logic [2:0] MASK_LAST  = 3'd3;

   phase_type              phase_ff, phase_in;
   logic [6:0]             type_ff, type_in;
   logic                   mask_ff, mask_in;
   logic [2:0]             cnt_ff, cnt_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;    // counts down through the payload
   logic [31:0]            key_ff, key_in;
   logic [1:0]             idx_ff, idx_in;
   logic                   len_done, key_done, emit;
   logic [7:0]             key_byte;
   logic [LENGTH_BITS-1:0] len_shift;
   wsd_pkg::rsp_type       res_c;

   always_comb begin
      if (len_ff[LENGTH_BITS-1 -: 8] != 8'd0) begin
         len_shift = '1;
      end else begin
         len_shift = {len_ff[LENGTH_BITS-9:0], rx_byte};
      end
   end

   assign key_byte = key_ff[{~idx_ff, 3'b000} +: 8];

   always_comb begin
      phase_in = phase_ff;
      type_in  = type_ff;
      mask_in  = mask_ff;
      cnt_in   = cnt_ff;
      len_in   = len_ff;
      key_in   = key_ff;
      idx_in   = idx_ff;
      len_done = 1'b0;
      key_done = 1'b0;
      emit     = 1'b0;
      res_c    = '0;
      unique case (phase_ff)
         PH_HDR1: begin
            mask_in = rx_byte[7];
            key_in  = '0;
            cnt_in  = '0;
            if (rx_byte[6:0] == wsd_pkg::LEN_CODE_EXT16) begin
               len_in   = '0;
               phase_in = PH_EXT16;
            end else if (rx_byte[6:0] == wsd_pkg::LEN_CODE_EXT64) begin
               len_in   = '0;
               phase_in = PH_EXT64;
            end else begin
               len_in   = LENGTH_BITS'(rx_byte[6:0]);
               len_done = 1'b1;
            end
         end
         PH_EXT16, PH_EXT64: begin
            len_in = len_shift;
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == ((phase_ff == PH_EXT16) ? EXT16_LAST : EXT64_LAST)) begin
               len_done = 1'b1;
            end
         end
         PH_MASK: begin
            key_in = {key_ff[23:0], rx_byte};
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == MASK_LAST) begin
               key_done = 1'b1;
            end
         end
         PH_DATA: begin
            emit               = 1'b1;
            res_c.payload_byte = rx_byte ^ key_byte;
            res_c.message_type = type_ff;
            res_c.frame_end    = (len_ff == LENGTH_BITS'(1));
            len_in             = len_ff - LENGTH_BITS'(1);
            idx_in             = idx_ff + 2'd1;
            if (res_c.frame_end) begin
               phase_in = PH_HDR0;
            end
         end
         default: begin
            type_in  = rx_byte[6:0];
            phase_in = PH_HDR1;
         end
      endcase

      // Length known: fetch the key, or close the header
      if (len_done && mask_in) begin
         cnt_in   = '0;
         phase_in = PH_MASK;
      end else if (len_done || key_done) begin
         idx_in = '0;
         if (len_in == '0) begin
            emit               = 1'b1;
            res_c.message_type = type_ff;
            res_c.frame_end    = 1'b1;
            res_c.empty_frame  = 1'b1;
            phase_in           = PH_HDR0;
         end else begin
            phase_in = PH_DATA;
         end
      end
   end

   assign res_valid = byte_valid && emit;
   assign res       = res_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR0;
         type_ff  <= '0;
         mask_ff  <= 1'b0;
         cnt_ff   <= '0;
         len_ff   <= '0;
         key_ff   <= '0;
         idx_ff   <= '0;
      end else if (byte_valid) begin
         phase_ff <= phase_in;
         type_ff  <= type_in;
         mask_ff  <= mask_in;
         cnt_ff   <= cnt_in;
         len_ff   <= len_in;
         key_ff   <= key_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

/* hw/rtl/wsd_out_buf.sv */
module wsd_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  wsd_pkg::rsp_type push_data,
   output logic             in_ready,
   output logic             out_valid,
   input  logic             out_ready,
   output wsd_pkg::rsp_type out_data
);

   logic             main_valid_ff, main_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   wsd_pkg::rsp_type main_ff, main_in;
   wsd_pkg::rsp_type skid_ff, skid_in;
   logic             pop;

   assign pop       = main_valid_ff && out_ready;
   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // Upstream is held off; drain the skid into the main register
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

/* dv/websocket_frame_deframer_tb.sv */
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;

   localparam int LEN_BITS    = wsd_pkg::LENGTH_BITS_DEFAULT;
   localparam int CYCLE_LIMIT = 500000;

   typedef enum logic [2:0] {
      PH_FIRST, PH_SECOND, PH_LEN16, PH_LEN64, PH_KEY, PH_PAYLOAD
   } parse_phase_type;

   typedef enum int { LEN_SHORT, LEN_EXT16, LEN_EXT64 } len_form_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   // deframer mirror
   parse_phase_type     phase      = PH_FIRST;
   logic [6:0]          cur_type   = '0;
   logic                has_key    = 1'b0;
   logic [3:0]          hdr_count  = '0;
   logic [LEN_BITS-1:0] frame_len  = '0;
   logic [31:0]         key_word   = '0;
   logic [63:0]         bytes_seen = '0;

   wsd_pkg::rsp_type deframed_queue[$];
   wsd_pkg::rsp_type seen_rsp, want_rsp;

   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int long_stall_req = 0;
   int stall_left     = 0;
   int rx_bytes_sent  = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   websocket_frame_deframer #(.LENGTH_BITS(LEN_BITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic void finish_header();
      wsd_pkg::rsp_type r;
      bytes_seen = '0;
      if (frame_len == 0) begin
         r = '0;
         r.message_type = cur_type;
         r.frame_end    = 1'b1;
         r.empty_frame  = 1'b1;
         deframed_queue.insert(deframed_queue.size(), r);
         phase = PH_FIRST;
      end else begin
         phase = PH_PAYLOAD;
      end
   endfunction

   function automatic void finish_length();
      if (has_key) begin
         hdr_count = '0;
         phase = PH_KEY;
      end else begin
         finish_header();
      end
   endfunction

   function automatic void deframe_byte(input logic [7:0] b);
      wsd_pkg::rsp_type r;
      logic [7:0]       k;
      case (phase)
         PH_SECOND: begin
            has_key   = b[7];
            key_word  = '0;
            hdr_count = '0;
            if (b[6:0] == wsd_pkg::LEN_CODE_EXT16) begin
               frame_len = '0;
               phase = PH_LEN16;
            end else if (b[6:0] == wsd_pkg::LEN_CODE_EXT64) begin
               frame_len = '0;
               phase = PH_LEN64;
            end else begin
               frame_len = LEN_BITS'(b[6:0]);
               finish_length();
            end
         end
         PH_LEN16, PH_LEN64: begin
            // saturate once the top byte is occupied
            if (frame_len[LEN_BITS-1 -: 8] != 0)
               frame_len = '1;
            else
               frame_len = {frame_len[LEN_BITS-9:0], b};
            hdr_count = hdr_count + 4'd1;
            if (hdr_count >= ((phase == PH_LEN16) ? 2 : 8))
               finish_length();
         end
         PH_KEY: begin
            key_word  = {key_word[23:0], b};
            hdr_count = hdr_count + 4'd1;
            if (hdr_count >= 4)
               finish_header();
         end
         PH_PAYLOAD: begin
            // key byte 0 sits in the top byte of the key word
            k = 8'(key_word >> (8 * (3 - int'(bytes_seen[1:0]))));
            r = '0;
            r.payload_byte = b ^ k;
            r.message_type = cur_type;
            bytes_seen = bytes_seen + 64'd1;
            if (bytes_seen >= frame_len) begin
               r.frame_end = 1'b1;
               phase = PH_FIRST;
            end
            deframed_queue.insert(deframed_queue.size(), r);
         end
         default: begin
            cur_type = b[6:0];
            phase = PH_SECOND;
         end
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      deframe_byte(b);
      rx_bytes_sent++;
   endtask

   task automatic send_frame(input logic [7:0] first, input bit masked,
                             input int unsigned len, input len_form_type form);
      logic [63:0] len64;
      len64 = 64'(len);
      send_byte(first);
      case (form)
         LEN_SHORT: send_byte({masked, len64[6:0]});
         LEN_EXT16: begin
            send_byte({masked, wsd_pkg::LEN_CODE_EXT16});
            send_byte(len64[15:8]);
            send_byte(len64[7:0]);
         end
         default: begin
            send_byte({masked, wsd_pkg::LEN_CODE_EXT64});
            for (int i = 7; i >= 0; i--) send_byte(len64[8*i +: 8]);
         end
      endcase
      if (masked) repeat (4) send_byte(8'($urandom_range(255)));
      repeat (len) send_byte(8'($urandom_range(255)));
   endtask

   task automatic send_random_frame();
      int unsigned pick;
      int unsigned len;
      bit          masked;
      pick   = $urandom_range(9);
      masked = 1'($urandom_range(1));
      len    = ($urandom_range(15) == 0) ? $urandom_range(125) : $urandom_range(6);
      if (pick < 6)
         send_frame(8'($urandom_range(255)), masked, len, LEN_SHORT);
      else if (pick < 8)
         send_frame(8'($urandom_range(255)), masked,
                    ($urandom_range(7) == 0) ? $urandom_range(300) : len, LEN_EXT16);
      else
         send_frame(8'($urandom_range(255)), masked, len, LEN_EXT64);
   endtask

   task automatic note_error(input string what, input wsd_pkg::rsp_type want,
                             input wsd_pkg::rsp_type got);
      string exp_part;
      mismatch_count++;
      if (mismatch_count <= 10) begin
         exp_part = $sformatf("%s: expected byte %02h type %02h end %0b empty %0b",
                              what, want.payload_byte, want.message_type,
                              want.frame_end, want.empty_frame);
         $display("%s, got byte %02h type %02h end %0b empty %0b",
                  exp_part, got.payload_byte, got.message_type,
                  got.frame_end, got.empty_frame);
      end
   endtask

   // rsp_ side: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (long_stall_req != 0) begin
         stall_left = long_stall_req;
         long_stall_req = 0;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_rsp.payload_byte = rsp_tdata[7:0];
         seen_rsp.message_type = rsp_tdata[14:8];
         seen_rsp.frame_end    = rsp_tlast;
         seen_rsp.empty_frame  = rsp_tuser;
         if (deframed_queue.size() == 0) begin
            note_error("unexpected transfer", '0, seen_rsp);
         end else begin
            want_rsp = deframed_queue.pop_front();
            if (seen_rsp.payload_byte !== want_rsp.payload_byte ||
                seen_rsp.message_type !== want_rsp.message_type ||
                seen_rsp.frame_end    !== want_rsp.frame_end ||
                seen_rsp.empty_frame  !== want_rsp.empty_frame)
               note_error("mismatch", want_rsp, seen_rsp);
         end
      end
   end

   task automatic test_directed_headers();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      // all type bits set, zero length
      send_byte(8'hFF); send_byte(8'h00);
      // masked zero length: empty transfer comes on the last key byte
      send_byte(8'h80); send_byte(8'h80);
      repeat (4) send_byte(8'h00);
      // unmasked payload passes unchanged
      send_byte(8'h82); send_byte(8'h02); send_byte(8'h00); send_byte(8'hFF);
      // masked, 16-bit length not minimally encoded, key byte order
      send_byte(8'h09); send_byte(8'hFE); send_byte(8'h00); send_byte(8'h03);
      send_byte(8'hFF); send_byte(8'h00); send_byte(8'hA5); send_byte(8'h5A);
      send_byte(8'hFF); send_byte(8'h00); send_byte(8'h3C);
   endtask

   task automatic test_random_stream(input int idle_pct, input int stall_pct);
      int start;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      start = rx_bytes_sent;
      while (rx_bytes_sent - start < 140) send_random_frame();
   endtask

   task automatic test_output_backpressure();
      send_idle_pct  = 0;
      rsp_stall_pct  = 0;
      long_stall_req = 200;
      // keep offering bytes so req_tready has to drop
      send_frame(8'h82, 1'b1, 60, LEN_SHORT);
   endtask

   task automatic test_unbounded_length();
      send_idle_pct = 10;
      rsp_stall_pct = 10;
      // top length bit set: accepted, frame never ends within the run
      send_byte(8'h81);
      send_byte({1'b1, wsd_pkg::LEN_CODE_EXT64});
      repeat (8) send_byte(8'hFF);
      repeat (4) send_byte(8'($urandom_range(255)));
      repeat (20) send_byte(8'($urandom_range(255)));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_headers();
      test_random_stream(0, 0);
      test_random_stream(82, 0);
      test_random_stream(0, 82);
      test_random_stream(10, 10);
      test_output_backpressure();
      test_unbounded_length();
      req_tvalid <= 1'b0;
      while (deframed_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && deframed_queue.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_parser.sv
hw/rtl/wsd_out_buf.sv
hw/rtl/websocket_frame_deframer.sv
dv/websocket_frame_deframer_tb.sv
